>>> sv/slot_cache_lru_manager_assert.svh
// Assertion macros shared by the slot cache manager RTL.
// Depends on nothing; the bodies compile away when SYNTHESIS is defined.
`ifndef SLOT_CACHE_LRU_MANAGER_ASSERT_SVH
`define SLOT_CACHE_LRU_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SCLM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define SCLM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SCLM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SCLM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/sclm_pkg.sv
// Types and codes for the slot cache manager.
// Used by the top level and the slot table; depends on nothing.
package sclm_pkg;

	localparam int unsigned SLOT_W = 6;

	typedef enum logic [1:0] {
		ST_EMPTY     = 2'd0,
		ST_REQUESTED = 2'd1,
		ST_LOADING   = 2'd2,
		ST_READY     = 2'd3
	} slot_st_t;

	typedef enum logic [2:0] {
		K_REQUEST = 3'd0,
		K_CLAIM   = 3'd1,
		K_RETRY   = 3'd2,
		K_RESERVE = 3'd3,
		K_PUBLISH = 3'd4,
		K_CONSUME = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		S_MISS      = 4'd0,
		S_HIT       = 4'd1,
		S_CLAIMED   = 4'd2,
		S_NONE      = 4'd3,
		S_EVICTED   = 4'd4,
		S_ROOM      = 4'd5,
		S_NO_ROOM   = 4'd6,
		S_DONE      = 4'd7,
		S_UPDATE    = 4'd8,
		S_NO_UPDATE = 4'd9,
		S_INVALID   = 4'd10
	} status_t;

	typedef enum logic [3:0] {
		FSM_IDLE, FSM_DECODE, FSM_CLAIM_RD, FSM_CLAIM_CK, FSM_RES_CHK,
		FSM_VIC_RD, FSM_VIC_CK, FSM_VIC_END, FSM_EMIT
	} fsm_t;

	// Write request into the slot table.
	typedef struct packed {
		logic              st_we;
		logic              dl_we;
		logic              lu_we;
		logic [SLOT_W-1:0] addr;
		slot_st_t          st;
		logic [31:0]       dl;
		logic [63:0]       lu;
	} tbl_wr_t;

	localparam logic [6:0]  PIN_NONE    = 7'h7F;
	localparam logic [6:0]  RC_MAX      = 7'd127;
	localparam logic [4:0]  EVICT_MAX   = 5'd31;
	localparam logic [5:0]  BUDGET_RST  = 6'd8;
	localparam logic [15:0] RETRY_RST   = 16'd3000;
	localparam logic        CFG_BUDGET  = 1'b0;
	localparam logic        CFG_RETRY   = 1'b1;

endpackage

>>> sv/slot_cache_lru_manager.sv
// Top level of the slot cache manager: sequencer, counters, output register.
// Depends on sclm_pkg, sclm_table, sclm_cmp and the assertion header.
//
// Channel  | Dir | Beat fields (low bit first)
// s_axis   | in  | tuser: kind[2:0]; tdata: slot[5:0], pin[6], now_ms[38:7]
// m_axis   | out | tdata: status[3:0], slot_out[9:4]; tlast: last
// cfg      | in  | cfg_addr 0 budget_tiles, 1 retry_delay_ms; cfg_wdata
//
// Request, retry, publish and consume pass through idle, decode and emit.
// Claim scans slots through the single memory read port, reading and then checking each slot.
// Reserve runs per eviction a budget check, a scan, a pick and an emit.
// Reset clears all control state; no clearing pass is needed.
// A stalled output holds the sequencer; s_tready is high only when idle.
module slot_cache_lru_manager #(
	parameter int unsigned SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // slot[5:0], pin[6], now_ms[38:7], zero[39]
	input  logic [2:0]  s_tuser,   // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // status[3:0], slot_out[9:4], zero[15:10]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata
);
	`include "slot_cache_lru_manager_assert.svh"

	localparam int unsigned IW = $clog2(SLOTS);
	localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);
	localparam logic [6:0] SLOTS_W = 7'(SLOTS);

	sclm_pkg::fsm_t state_q, state_d;

	// Latched item.
	logic [2:0]  kind_q;
	logic [5:0]  slot_q;
	logic        pin_q;
	logic [31:0] now_q;

	// Configuration and global state.
	logic [5:0]  budget_q;
	logic [15:0] retry_q;
	logic [63:0] ord_q;
	logic [6:0]  rc_q;
	logic [6:0]  pinned_q;
	logic        upd_q;

	// Scan state.
	logic [IW-1:0] idx_q;
	logic [IW-1:0] best_q;
	logic [63:0]   best_lu_q;
	logic          best_vld_q;
	logic [4:0]    evict_q;

	// Pending result and output register.
	sclm_pkg::status_t emit_status_q, emit_status_d;
	logic [5:0]  emit_slot_q, emit_slot_d;
	logic        emit_last_q, emit_last_d;
	logic        emit_set;
	logic        m_tvalid_q;
	logic [3:0]  m_status_q;
	logic [5:0]  m_slot_q;
	logic        m_last_q;
	logic        out_free;

	// Controls from the sequencer.
	sclm_pkg::tbl_wr_t tbl_wr;
	logic [IW-1:0] st_raddr;
	sclm_pkg::slot_st_t st_rdata;
	logic [31:0] dl_rdata;
	logic [63:0] lu_rdata;
	logic        passed, lu_less;
	logic        idx_ld1, idx_inc, best_clr, best_upd;
	logic        ord_inc, pin_set, rc_inc, rc_dec, upd_set, upd_clr;
	logic        evict_inc, evict_clr;

	logic        slot_ok;
	logic        has_room;
	logic [IW-1:0] slot_idx;
	logic [63:0] ord_next;

	assign slot_ok  = (slot_q != 6'd0) && ({1'b0, slot_q} < SLOTS_W);
	assign slot_idx = slot_q[IW-1:0];
	assign has_room = ({1'b0, rc_q} + 8'd1) <= {2'b00, budget_q};
	assign ord_next = ord_q + 64'd1;
	assign out_free = !m_tvalid_q || m_tready;
	assign st_raddr = (state_q == sclm_pkg::FSM_DECODE) ? slot_idx : idx_q;

	sclm_table #(.SLOTS(SLOTS)) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.st_raddr (st_raddr),
		.st_rdata (st_rdata),
		.mem_raddr(idx_q),
		.dl_rdata (dl_rdata),
		.lu_rdata (lu_rdata)
	);

	sclm_cmp u_cmp (
		.now_ms  (now_q),
		.deadline(dl_rdata),
		.lu_a    (lu_rdata),
		.lu_b    (best_lu_q),
		.passed  (passed),
		.lu_less (lu_less)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sclm_pkg::FSM_IDLE:
				if (s_tvalid) state_d = sclm_pkg::FSM_DECODE;
			sclm_pkg::FSM_DECODE: begin
				if (kind_q == sclm_pkg::K_CLAIM) state_d = sclm_pkg::FSM_CLAIM_RD;
				else if (kind_q == sclm_pkg::K_RESERVE) state_d = sclm_pkg::FSM_RES_CHK;
				else state_d = sclm_pkg::FSM_EMIT;
			end
			sclm_pkg::FSM_CLAIM_RD: state_d = sclm_pkg::FSM_CLAIM_CK;
			sclm_pkg::FSM_CLAIM_CK: begin
				if ((st_rdata == sclm_pkg::ST_REQUESTED && passed) || idx_q == IDX_LAST)
					state_d = sclm_pkg::FSM_EMIT;
				else
					state_d = sclm_pkg::FSM_CLAIM_RD;
			end
			sclm_pkg::FSM_RES_CHK: begin
				if (has_room || evict_q == sclm_pkg::EVICT_MAX) state_d = sclm_pkg::FSM_EMIT;
				else state_d = sclm_pkg::FSM_VIC_RD;
			end
			sclm_pkg::FSM_VIC_RD: state_d = sclm_pkg::FSM_VIC_CK;
			sclm_pkg::FSM_VIC_CK:
				state_d = (idx_q == IDX_LAST) ? sclm_pkg::FSM_VIC_END : sclm_pkg::FSM_VIC_RD;
			sclm_pkg::FSM_VIC_END: state_d = sclm_pkg::FSM_EMIT;
			sclm_pkg::FSM_EMIT:
				if (out_free) state_d = emit_last_q ? sclm_pkg::FSM_IDLE : sclm_pkg::FSM_RES_CHK;
			default: state_d = sclm_pkg::FSM_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		tbl_wr        = '0;
		tbl_wr.st     = sclm_pkg::ST_EMPTY;
		tbl_wr.addr   = 6'(idx_q);
		emit_set      = 1'b0;
		emit_status_d = sclm_pkg::S_INVALID;
		emit_slot_d   = 6'd0;
		emit_last_d   = 1'b1;
		idx_ld1 = 1'b0; idx_inc = 1'b0; best_clr = 1'b0; best_upd = 1'b0;
		ord_inc = 1'b0; pin_set = 1'b0; rc_inc = 1'b0; rc_dec = 1'b0;
		upd_set = 1'b0; upd_clr = 1'b0; evict_inc = 1'b0; evict_clr = 1'b0;
		unique case (state_q)
			sclm_pkg::FSM_DECODE: begin
				tbl_wr.addr = slot_q;
				emit_set    = 1'b1;
				case (kind_q)
					sclm_pkg::K_REQUEST: begin
						if (!slot_ok) begin
							emit_status_d = sclm_pkg::S_INVALID;
						end else if (st_rdata == sclm_pkg::ST_READY) begin
							ord_inc       = 1'b1;
							pin_set       = pin_q;
							tbl_wr.lu_we  = 1'b1;
							tbl_wr.lu     = ord_next;
							emit_status_d = sclm_pkg::S_HIT;
							emit_slot_d   = slot_q;
						end else begin
							if (st_rdata == sclm_pkg::ST_EMPTY) begin
								tbl_wr.st_we = 1'b1;
								tbl_wr.st    = sclm_pkg::ST_REQUESTED;
								tbl_wr.dl_we = 1'b1;
								tbl_wr.dl    = 32'd0;
							end
							emit_status_d = sclm_pkg::S_MISS;
						end
					end
					sclm_pkg::K_CLAIM: begin
						emit_set = 1'b0;
						idx_ld1  = 1'b1;
					end
					sclm_pkg::K_RETRY: begin
						if (!slot_ok) begin
							emit_status_d = sclm_pkg::S_INVALID;
						end else begin
							rc_dec       = (st_rdata == sclm_pkg::ST_READY) && (rc_q != 7'd0);
							tbl_wr.st_we = 1'b1;
							tbl_wr.st    = sclm_pkg::ST_REQUESTED;
							tbl_wr.dl_we = 1'b1;
							tbl_wr.dl    = now_q + {16'd0, retry_q};
							emit_status_d = sclm_pkg::S_DONE;
						end
					end
					sclm_pkg::K_RESERVE: begin
						emit_set  = 1'b0;
						evict_clr = 1'b1;
					end
					sclm_pkg::K_PUBLISH: begin
						if (!slot_ok) begin
							emit_status_d = sclm_pkg::S_INVALID;
						end else begin
							ord_inc      = 1'b1;
							tbl_wr.lu_we = 1'b1;
							tbl_wr.lu    = ord_next;
							rc_inc       = (st_rdata != sclm_pkg::ST_READY) &&
							               (rc_q != sclm_pkg::RC_MAX);
							tbl_wr.st_we = 1'b1;
							tbl_wr.st    = sclm_pkg::ST_READY;
							upd_set      = 1'b1;
							emit_status_d = sclm_pkg::S_DONE;
						end
					end
					sclm_pkg::K_CONSUME: begin
						upd_clr       = 1'b1;
						emit_status_d = upd_q ? sclm_pkg::S_UPDATE : sclm_pkg::S_NO_UPDATE;
					end
					default: emit_status_d = sclm_pkg::S_INVALID;
				endcase
			end
			sclm_pkg::FSM_CLAIM_CK: begin
				if (st_rdata == sclm_pkg::ST_REQUESTED && passed) begin
					tbl_wr.st_we  = 1'b1;
					tbl_wr.st     = sclm_pkg::ST_LOADING;
					emit_set      = 1'b1;
					emit_status_d = sclm_pkg::S_CLAIMED;
					emit_slot_d   = 6'(idx_q);
				end else if (idx_q == IDX_LAST) begin
					emit_set      = 1'b1;
					emit_status_d = sclm_pkg::S_NONE;
				end else begin
					idx_inc = 1'b1;
				end
			end
			sclm_pkg::FSM_RES_CHK: begin
				if (has_room) begin
					emit_set      = 1'b1;
					emit_status_d = sclm_pkg::S_ROOM;
				end else if (evict_q == sclm_pkg::EVICT_MAX) begin
					emit_set      = 1'b1;
					emit_status_d = sclm_pkg::S_NO_ROOM;
				end else begin
					idx_ld1  = 1'b1;
					best_clr = 1'b1;
				end
			end
			sclm_pkg::FSM_VIC_CK: begin
				best_upd = (st_rdata == sclm_pkg::ST_READY) &&
				           ({1'b0, 6'(idx_q)} != pinned_q) && (!best_vld_q || lu_less);
				idx_inc  = (idx_q != IDX_LAST);
			end
			sclm_pkg::FSM_VIC_END: begin
				emit_set = 1'b1;
				if (!best_vld_q) begin
					emit_status_d = sclm_pkg::S_NO_ROOM;
				end else begin
					tbl_wr.addr   = 6'(best_q);
					tbl_wr.st_we  = 1'b1;
					tbl_wr.st     = sclm_pkg::ST_EMPTY;
					rc_dec        = (rc_q != 7'd0);
					evict_inc     = 1'b1;
					emit_status_d = sclm_pkg::S_EVICTED;
					emit_slot_d   = 6'(best_q);
					emit_last_d   = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sclm_pkg::FSM_IDLE;
			budget_q   <= sclm_pkg::BUDGET_RST;
			retry_q    <= sclm_pkg::RETRY_RST;
			ord_q      <= 64'd0;
			rc_q       <= 7'd0;
			pinned_q   <= sclm_pkg::PIN_NONE;
			upd_q      <= 1'b0;
			evict_q    <= 5'd0;
			best_vld_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_addr == sclm_pkg::CFG_BUDGET) budget_q <= cfg_wdata[5:0];
			if (cfg_we && cfg_addr == sclm_pkg::CFG_RETRY) retry_q <= cfg_wdata;
			if (ord_inc) ord_q <= ord_next;
			if (pin_set) pinned_q <= {1'b0, slot_q};
			if (rc_inc) rc_q <= rc_q + 7'd1;
			else if (rc_dec) rc_q <= rc_q - 7'd1;
			if (upd_set) upd_q <= 1'b1;
			else if (upd_clr) upd_q <= 1'b0;
			if (evict_clr) evict_q <= 5'd0;
			else if (evict_inc) evict_q <= evict_q + 5'd1;
			if (best_clr) best_vld_q <= 1'b0;
			else if (best_upd) best_vld_q <= 1'b1;
			if (state_q == sclm_pkg::FSM_EMIT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			slot_q <= s_tdata[5:0];
			pin_q  <= s_tdata[6];
			now_q  <= s_tdata[38:7];
		end
		if (idx_ld1) idx_q <= IW'(1);
		else if (idx_inc) idx_q <= idx_q + IW'(1);
		if (best_upd) begin
			best_q    <= idx_q;
			best_lu_q <= lu_rdata;
		end
		if (emit_set) begin
			emit_status_q <= emit_status_d;
			emit_slot_q   <= emit_slot_d;
			emit_last_q   <= emit_last_d;
		end
		if (state_q == sclm_pkg::FSM_EMIT && out_free) begin
			m_status_q <= emit_status_q;
			m_slot_q   <= emit_slot_q;
			m_last_q   <= emit_last_q;
		end
	end

	assign s_tready = (state_q == sclm_pkg::FSM_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, m_slot_q, m_status_q};
	assign m_tlast  = m_last_q;

	// The chosen victim is never slot zero and never the pinned slot.
	logic u_table_ok;
	assign u_table_ok = ({1'b0, 6'(best_q)} != pinned_q) && (best_q != IW'(0));

	`SCLM_ASSERT_NXT(a_accept_busy, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`SCLM_ASSERT_NXT(a_emit_shows, clk, arst_n, state_q == sclm_pkg::FSM_EMIT && out_free, m_tvalid)
	`SCLM_ASSERT_IMP(a_evict_ready, clk, arst_n, state_q == sclm_pkg::FSM_VIC_END && best_vld_q, u_table_ok)
	`SCLM_ASSERT_IMP(a_evict_bound, clk, arst_n, evict_inc, evict_q != sclm_pkg::EVICT_MAX)
endmodule

>>> sv/sclm_table.sv
// Slot table: state flops per slot, deadline and last-use memories.
// Depends on sclm_pkg.
module sclm_table #(
	parameter int unsigned SLOTS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sclm_pkg::tbl_wr_t      wr,
	input  logic [$clog2(SLOTS)-1:0] st_raddr,
	output sclm_pkg::slot_st_t     st_rdata,
	input  logic [$clog2(SLOTS)-1:0] mem_raddr,
	output logic [31:0]            dl_rdata,
	output logic [63:0]            lu_rdata
);
	localparam int unsigned IW = $clog2(SLOTS);

	sclm_pkg::slot_st_t st_q [SLOTS];
	logic [31:0] dl_mem [SLOTS];
	logic [63:0] lu_mem [SLOTS];
	logic [IW-1:0] waddr;

	assign waddr = wr.addr[IW-1:0];

	// Slot states reset to empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) st_q[i] <= sclm_pkg::ST_EMPTY;
		end else if (wr.st_we) begin
			st_q[waddr] <= wr.st;
		end
	end

	assign st_rdata = st_q[st_raddr];

	// Deadline memory, one write and one registered read port.
	always_ff @(posedge clk) begin
		if (wr.dl_we) dl_mem[waddr] <= wr.dl;
		dl_rdata <= dl_mem[mem_raddr];
	end

	// Last-use memory, one write and one registered read port.
	always_ff @(posedge clk) begin
		if (wr.lu_we) lu_mem[waddr] <= wr.lu;
		lu_rdata <= lu_mem[mem_raddr];
	end
endmodule

>>> sv/sclm_cmp.sv
// Shared compare unit: deadline-passed test and last-use ordering.
// Depends on nothing.
module sclm_cmp (
	input  logic [31:0] now_ms,
	input  logic [31:0] deadline,
	input  logic [63:0] lu_a,
	input  logic [63:0] lu_b,
	output logic        passed,
	output logic        lu_less
);
	logic [31:0] diff;

	// A deadline has passed when the wrapped difference is non-negative.
	assign diff    = now_ms - deadline;
	assign passed  = ~diff[31];
	assign lu_less = lu_a < lu_b;
endmodule
